// ----- src/sorted_stats_histogram_macros.svh -----
// ----------------------------------------------------------------------------
// sorted_stats_histogram assertion macros
// shared property wrappers, clocked on i_clk and quiet during reset
// ----------------------------------------------------------------------------
`ifndef SORTED_STATS_HISTOGRAM_MACROS_SVH
`define SORTED_STATS_HISTOGRAM_MACROS_SVH

// same-cycle implication
`define SSH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SSH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/ssh_pkg.sv -----
// ----------------------------------------------------------------------------
// ssh_pkg
// types and constants shared by the sorted statistics histogram
// ----------------------------------------------------------------------------
package ssh_pkg;

    localparam int VAL_W    = 32;
    localparam int CFG_W    = 7;
    localparam int BAR_W    = 5;
    localparam int BAR_2X   = 50;  // twice the bar scale of 25
    localparam int BIN_IX_W = 6;
    localparam int CNT_W    = 11;
    localparam logic [CFG_W-1:0] BINS_RESET = 7'd10;

    typedef struct packed {
        logic signed [VAL_W-1:0] sample_value;
        logic                    set_end;
    } t_sample;

    typedef struct packed {
        logic [BIN_IX_W-1:0]     bin_index;
        logic [CNT_W-1:0]        bin_count;
        logic [BAR_W-1:0]        bar_length;
        logic signed [VAL_W-1:0] median_value;
        logic signed [VAL_W-1:0] minimum_value;
        logic signed [VAL_W-1:0] maximum_value;
        logic [CNT_W-1:0]        total_count;
        logic                    overflow_flag;
        logic                    run_end;
    } t_result;

    // what one cell shows its neighbors
    typedef struct packed {
        logic                    vld;
        logic                    gt;
        logic signed [VAL_W-1:0] val;
    } t_link;

    typedef struct packed {
        logic ld;
        logic sh;
    } t_cell_ctl;

    localparam t_link LINK_HEAD = '{vld: 1'b1, gt: 1'b0, val: '0};
    localparam t_link LINK_TAIL = '{vld: 1'b0, gt: 1'b0, val: '0};

endpackage

// ----- src/ssh_cell.sv -----
// ----------------------------------------------------------------------------
// ssh_cell
// one slot of the insertion sorting chain, also drains toward the head
// ----------------------------------------------------------------------------
module ssh_cell
    import ssh_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cell_ctl               i_ctl,
    input  logic signed [VAL_W-1:0] i_val,
    input  t_link                   i_left,
    input  t_link                   i_right,
    output t_link                   o_link
);

    logic                    r_vld;
    logic signed [VAL_W-1:0] r_val;
    logic                    w_gt;
    logic                    w_take;

    assign w_gt   = r_vld && (r_val > i_val);
    // occupied and larger: shift; empty with filled left: append
    assign w_take = r_vld ? w_gt : i_left.vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.sh) begin
            r_vld <= i_right.vld;
        end else if (i_ctl.ld && w_take) begin
            r_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.sh) begin
            r_val <= i_right.val;
        end else if (i_ctl.ld && w_take) begin
            r_val <= i_left.gt ? i_left.val : i_val;
        end
    end

    assign o_link = '{vld: r_vld, gt: w_gt, val: r_val};

endmodule

// ----- src/ssh_bar_div.sv -----
// ----------------------------------------------------------------------------
// ssh_bar_div
// restoring divider for the bar length, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ssh_bar_div
    import ssh_pkg::*;
#(
    parameter int CW = 11
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [CW+5:0]     i_num,
    input  logic [CW:0]       i_den,
    output logic              o_done,
    output logic [BAR_W-1:0]  o_q
);

    logic [CW+5:0]          r_rem;
    logic [CW:0]            r_den;
    logic [2:0]             r_i;
    logic                   r_busy;
    logic [BAR_W-1:0]       r_q;
    logic                   r_done;
    logic [CW+5:0]          w_sub;
    logic                   w_fit;

    assign w_sub = (CW+6)'(r_den) << r_i;
    assign w_fit = r_rem >= w_sub;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rem  <= i_num;
                r_den  <= i_den;
                r_i    <= 3'(BAR_W - 1);
                r_q    <= '0;
            end else if (r_busy) begin
                if (w_fit) begin
                    r_rem <= r_rem - w_sub;
                end
                r_q[r_i[2:0]] <= w_fit;
                if (r_i == 3'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_i <= r_i - 3'd1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule

// ----- src/sorted_stats_histogram.sv -----
// ----------------------------------------------------------------------------
// sorted_stats_histogram
// sorts a set of values in a cell chain and reports an equal-width histogram
// ----------------------------------------------------------------------------
// usage
//   input beats carry one signed value and a set_end mark; one value is taken
//   per cycle while ready is high and is sorted into the cell chain on that edge
//   the cfg channel writes num_bins; it is always ready, write it while idle
//   values beyond MAX_VALUES are dropped and the set reports overflow_flag
//   after the beat with set_end, input ready drops; the chain drains one
//   value per cycle into the binning walk while the head value fits the
//   current bin; bins advance only while the head value no longer fits
//   then one result beat per bin: a memory read state, a divider start state
//   and the divider state (five quotient bits, then the done strobe) for the bar
//   length, then the output state, which waits for the receiver to take it
//   a stalled receiver simply holds the result register; nothing is lost
//   after the beat with run_end the block returns to loading a new set
//   reset is synchronous, clears the chain valid bits, value count, overflow mark,
//   output valid and state, and sets num_bins to 10; no clearing pass is needed
// ----------------------------------------------------------------------------
`include "sorted_stats_histogram_macros.svh"

module sorted_stats_histogram
    import ssh_pkg::*;
#(
    parameter int MAX_VALUES = 1024,
    parameter int MAX_BINS   = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_sample          i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_result          o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int CW  = $clog2(MAX_VALUES + 1);
    localparam int BW  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int THW = VAL_W + CFG_W;

    typedef enum logic [2:0] {
        S_LOAD,
        S_PREP,
        S_BIN,
        S_RD,
        S_DGO,
        S_DIV,
        S_OUT
    } t_state;

    t_state                  r_state;
    logic [CFG_W-1:0]        r_cfg;
    logic [CFG_W-1:0]        r_bins;
    logic [CW-1:0]           r_count;
    logic                    r_dropped;
    logic signed [VAL_W-1:0] r_min;
    logic signed [VAL_W-1:0] r_max;
    logic signed [VAL_W-1:0] r_med;
    logic [CW-1:0]           r_j;
    logic [BW-1:0]           r_b;
    logic [THW-1:0]          r_thr;
    logic [CW-1:0]           r_cnt;
    logic [CW-1:0]           r_largest;
    logic [BW-1:0]           r_k;
    logic [CW-1:0]           r_rd;
    logic                    r_out_valid;
    t_result                 r_out;

    logic [CW-1:0]           r_mem [MAX_BINS];

    // chain wiring
    t_link                   w_link [MAX_VALUES];
    t_cell_ctl               w_ctl;

    logic                    w_in_acc;
    logic                    w_ld;
    logic [CFG_W-1:0]        w_bins_eff;
    logic [VAL_W:0]          w_range_x;
    logic [VAL_W-1:0]        w_range;
    logic [VAL_W:0]          w_d_x;
    logic [THW-1:0]          w_prod;
    logic                    w_fit;
    logic                    w_drain;
    logic                    w_last_bin;
    logic                    w_mem_we;
    logic                    w_div_start;
    logic                    w_div_done;
    logic [BAR_W-1:0]        w_bar;
    logic [CW+5:0]           w_num;
    logic [CW:0]             w_den;

    assign o_in_ready  = (r_state == S_LOAD);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_ld        = w_in_acc && (r_count < CW'(MAX_VALUES));

    // zero bins means one, too many clamps to the memory depth
    always_comb begin
        if (r_cfg == '0) begin
            w_bins_eff = CFG_W'(1);
        end else if (r_cfg > CFG_W'(MAX_BINS)) begin
            w_bins_eff = CFG_W'(MAX_BINS);
        end else begin
            w_bins_eff = r_cfg;
        end
    end

    // values arrive in order at the chain head, so bins only move forward:
    // the head fits bin b while (v-min)*bins <= (b+1)*range
    assign w_range_x  = {r_max[VAL_W-1], r_max} - {r_min[VAL_W-1], r_min};
    assign w_range    = w_range_x[VAL_W-1:0];
    assign w_d_x      = {w_link[0].val[VAL_W-1], w_link[0].val} - {r_min[VAL_W-1], r_min};
    assign w_prod     = THW'(w_d_x[VAL_W-1:0]) * THW'(r_bins);
    assign w_fit      = w_prod <= r_thr;
    assign w_drain    = (r_state == S_BIN) && (r_j < r_count) && w_fit;
    assign w_last_bin = (r_b == BW'(r_bins - CFG_W'(1)));
    assign w_mem_we   = (r_state == S_BIN) && !w_drain;

    assign w_ctl = '{ld: w_ld, sh: w_drain};

    genvar g;
    generate
        for (g = 0; g < MAX_VALUES; g++) begin : g_cell
            t_link w_left;
            t_link w_right;
            if (g == 0) begin : g_head
                assign w_left = LINK_HEAD;
            end else begin : g_mid_l
                assign w_left = w_link[g-1];
            end
            if (g == MAX_VALUES - 1) begin : g_tail
                assign w_right = LINK_TAIL;
            end else begin : g_mid_r
                assign w_right = w_link[g+1];
            end
            ssh_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_val   (i_in_data.sample_value),
                .i_left  (w_left),
                .i_right (w_right),
                .o_link  (w_link[g])
            );
        end
    endgenerate

    // per-bin counts, written as the walk leaves a bin
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_b] <= r_cnt;
        end
        r_rd <= r_mem[r_k];
    end

    // bar = (50*c + largest) / (2*largest), rounded half up
    assign w_num       = (CW+6)'(r_rd) * (CW+6)'(BAR_2X) + (CW+6)'(r_largest);
    assign w_den       = {r_largest, 1'b0};
    assign w_div_start = (r_state == S_DGO);

    ssh_bar_div #(
        .CW (CW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_q     (w_bar)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_cfg       <= BINS_RESET;
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg <= i_cfg_data;
            end
            case (r_state)
                S_LOAD: begin
                    if (w_ld) begin
                        r_count <= r_count + CW'(1);
                        if (r_count == '0) begin
                            r_min <= i_in_data.sample_value;
                            r_max <= i_in_data.sample_value;
                        end else begin
                            if (i_in_data.sample_value < r_min) begin
                                r_min <= i_in_data.sample_value;
                            end
                            if (i_in_data.sample_value > r_max) begin
                                r_max <= i_in_data.sample_value;
                            end
                        end
                    end
                    if (w_in_acc && !w_ld) begin
                        r_dropped <= 1'b1;
                    end
                    if (w_in_acc && i_in_data.set_end) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_bins    <= w_bins_eff;
                    r_b       <= '0;
                    r_thr     <= THW'(w_range);
                    r_cnt     <= '0;
                    r_j       <= '0;
                    r_largest <= '0;
                    r_state   <= S_BIN;
                end
                S_BIN: begin
                    if (w_drain) begin
                        r_cnt <= r_cnt + CW'(1);
                        r_j   <= r_j + CW'(1);
                        if (r_j == (r_count >> 1)) begin
                            r_med <= w_link[0].val;
                        end
                    end else begin
                        if (r_cnt > r_largest) begin
                            r_largest <= r_cnt;
                        end
                        if (w_last_bin) begin
                            r_k     <= '0;
                            r_state <= S_RD;
                        end else begin
                            r_b   <= r_b + BW'(1);
                            r_thr <= r_thr + THW'(w_range);
                            r_cnt <= '0;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_DGO;
                end
                S_DGO: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_out.bin_index     <= BIN_IX_W'(r_k);
                        r_out.bin_count     <= CNT_W'(r_rd);
                        r_out.bar_length    <= w_bar;
                        r_out.median_value  <= r_med;
                        r_out.minimum_value <= r_min;
                        r_out.maximum_value <= r_max;
                        r_out.total_count   <= CNT_W'(r_count);
                        r_out.overflow_flag <= r_dropped;
                        r_out.run_end       <= (r_k == BW'(r_bins - CFG_W'(1)));
                        r_out_valid         <= 1'b1;
                        r_state             <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        if (r_out.run_end) begin
                            r_count   <= '0;
                            r_dropped <= 1'b0;
                            r_state   <= S_LOAD;
                        end else begin
                            r_k     <= r_k + BW'(1);
                            r_state <= S_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // loading and reporting never overlap
    `SSH_ASSERT_NOW(a_no_overlap, o_in_ready, !o_out_valid, "input ready while a result is pending")
    // the store never counts past its capacity
    `SSH_ASSERT_NOW(a_count_cap, r_state == S_LOAD, r_count <= CW'(MAX_VALUES), "stored count above capacity")
    // the bin walk stays inside the configured bins
    `SSH_ASSERT_NOW(a_bin_range, r_state == S_BIN, r_b < BW'(r_bins) || r_bins == CFG_W'(MAX_BINS), "bin walk past last bin")
    // the final beat of a set hands control back to loading
    `SSH_ASSERT_NEXT(a_run_end, o_out_valid && i_out_ready && o_out_data.run_end, o_in_ready, "no return to loading after the last bin")

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// sorted_stats_histogram testbench
// feeds value sets under random gaps and stalls, predicts every bin beat and
// compares each result beat in full against the predicted bins
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb
    import ssh_pkg::*;
();

    localparam int NVALS      = 1024;
    localparam int NBINS      = 64;
    localparam int WDOG_LIMIT = 200000;

    logic    i_clk;
    logic    i_rst_n;
    logic    i_in_valid;
    logic    o_in_ready;
    t_sample i_in_data;
    logic    o_out_valid;
    logic    i_out_ready;
    t_result o_out_data;
    logic    i_cfg_valid;
    logic    o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data;

    // predictor state: sorted copy of the current set
    logic signed [VAL_W-1:0] set_vals[$];
    bit          set_dropped;
    int unsigned bins_reg;

    t_result bins_expected[$];
    int      n_err;
    int      wdog;
    int      stall_cnt;
    bit      hold_ready;

    // directed rows: value, end mark, expected typed in where it is obvious
    typedef struct {
        logic signed [VAL_W-1:0] v;
        bit                      last;
        bit                      typed;
        logic [CNT_W-1:0]        cnt0;
    } t_row;

    t_row dir_rows[$];

    sorted_stats_histogram dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // sort one value into the set, then on the end mark predict all bin beats
    task automatic histogram_predict(input logic signed [VAL_W-1:0] v, input bit last);
        int unsigned nb, pos, largest, n;
        longint vmin, vmax, d, rng, b;
        int unsigned cnt[NBINS];
        t_result r;
        if (set_vals.size() < NVALS) begin
            pos = set_vals.size();
            while (pos > 0 && set_vals[pos-1] > v) pos--;
            set_vals.insert(pos, v);
        end else begin
            set_dropped = 1'b1;
        end
        if (!last) return;
        nb = bins_reg;
        if (nb < 1) nb = 1;
        if (nb > NBINS) nb = NBINS;
        n = set_vals.size();
        vmin = set_vals[0];
        vmax = set_vals[n-1];
        rng = vmax - vmin;
        foreach (cnt[i]) cnt[i] = 0;
        foreach (set_vals[j]) begin
            d = longint'(set_vals[j]) - vmin;
            b = 0;
            // exact equal-width test; maximum lands in the last bin
            if (rng != 0 && d != 0) b = (d * nb + rng - 1) / rng - 1;
            if (b >= nb) b = nb - 1;
            cnt[b]++;
        end
        largest = 0;
        for (int i = 0; i < nb; i++) if (cnt[i] > largest) largest = cnt[i];
        if (largest == 0) largest = 1;
        for (int i = 0; i < nb; i++) begin
            r.bin_index     = i[BIN_IX_W-1:0];
            r.bin_count     = cnt[i][CNT_W-1:0];
            r.bar_length    = BAR_W'((BAR_2X * cnt[i] + largest) / (2 * largest));
            r.median_value  = set_vals[n/2];
            r.minimum_value = vmin[VAL_W-1:0];
            r.maximum_value = vmax[VAL_W-1:0];
            r.total_count   = n[CNT_W-1:0];
            r.overflow_flag = set_dropped;
            r.run_end       = (i == nb - 1);
            bins_expected.push_back(r);
        end
        set_vals.delete();
        set_dropped = 1'b0;
    endtask

    function automatic int gap_len();
        // mostly short gaps, a few long ones, many zero
        int k;
        k = $urandom_range(0, 99);
        if (k < 45) return 0;
        if (k < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // valid drops only ahead of a real gap, so back to back beats keep it high
    task automatic send_sample(input logic signed [VAL_W-1:0] v, input bit last);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{sample_value: v, set_end: last};
        histogram_predict(v, last);
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // wait for every bin beat, then let the block settle before a cfg write
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (bins_expected.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_bins(input int unsigned nb);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= nb[CFG_W-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        bins_reg = nb;
    endtask

    function automatic logic signed [VAL_W-1:0] rand_val(input int mode);
        case (mode)
            0: return $urandom();
            1: return $signed($urandom_range(0, 40)) - 20;
            default: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
        endcase
    endfunction

    // receiver: random stalls, check every beat
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (bins_expected.size() == 0) begin
                    n_err++;
                    if (n_err <= 10) $display("unexpected bin beat %p", o_out_data);
                end else if (o_out_data !== bins_expected[0]) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("bin mismatch exp %p got %p", bins_expected[0], o_out_data);
                    void'(bins_expected.pop_front());
                end else begin
                    void'(bins_expected.pop_front());
                end
            end
            // stall pattern: one ready cycle, then a random hold; hold_ready keeps ready high
            if (hold_ready) begin
                i_out_ready <= 1'b1;
            end else if (stall_cnt > 0) begin
                i_out_ready <= 1'b0;
                stall_cnt   <= stall_cnt - 1;
            end else begin
                i_out_ready <= 1'b1;
                stall_cnt   <= gap_len();
            end
        end else begin
            stall_cnt <= 0;
        end
    end

    // watchdog on cycles with no accepted beat on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            wdog <= 0;
        end else begin
            wdog <= wdog + 1;
            if (wdog >= WDOG_LIMIT) begin
                $display("[sorted_stats_histogram] ERROR");
                $finish;
            end
        end
    end

    initial begin
        int unsigned cfg_list[$];
        int nset, mode;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        n_err       = 0;
        hold_ready  = 1'b0;
        bins_reg    = BINS_RESET;
        set_dropped = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single value at reset bins: all in bin 0, count 1
        dir_rows.push_back('{32'sd5, 1'b1, 1'b1, 11'd1});
        // extremes: most negative and most positive
        dir_rows.push_back('{32'sh80000000, 1'b0, 1'b0, 11'd0});
        dir_rows.push_back('{32'sh7fffffff, 1'b0, 1'b0, 11'd0});
        dir_rows.push_back('{32'sd0, 1'b0, 1'b0, 11'd0});
        dir_rows.push_back('{-32'sd1, 1'b1, 1'b0, 11'd0});
        // all values equal: everything in bin 0
        dir_rows.push_back('{32'sd7, 1'b0, 1'b0, 11'd0});
        dir_rows.push_back('{32'sd7, 1'b0, 1'b0, 11'd0});
        dir_rows.push_back('{32'sd7, 1'b1, 1'b1, 11'd3});
        // small set out of order
        dir_rows.push_back('{32'sd9, 1'b0, 1'b0, 11'd0});
        dir_rows.push_back('{32'sd3, 1'b0, 1'b0, 11'd0});
        dir_rows.push_back('{-32'sd4, 1'b0, 1'b0, 11'd0});
        dir_rows.push_back('{32'sd0, 1'b1, 1'b0, 11'd0});

        foreach (dir_rows[k]) begin
            if (dir_rows[k].typed && bins_expected.size() == 0) begin
                send_sample(dir_rows[k].v, dir_rows[k].last);
                if (bins_expected[0].bin_count !== dir_rows[k].cnt0) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("directed bin 0 count exp %0d got %0d",
                                 dir_rows[k].cnt0, bins_expected[0].bin_count);
                end
            end else begin
                send_sample(dir_rows[k].v, dir_rows[k].last);
            end
        end
        wait_idle();

        // bin settings in and out of range: 0 acts as 1, 127 acts as 64
        cfg_list = '{0, 127, 1, 64, 2, 17};
        foreach (cfg_list[c]) begin
            write_bins(cfg_list[c]);
            hold_ready = (c % 2 == 0);
            for (int s = 0; s < 4; s++) begin
                nset = $urandom_range(1, 7);
                mode = $urandom_range(0, 2);
                for (int j = 0; j < nset; j++)
                    send_sample(rand_val(mode), j == nset - 1);
            end
            wait_idle();
        end

        if (n_err == 0 && bins_expected.size() == 0)
            $display("[sorted_stats_histogram] OK");
        else
            $display("[sorted_stats_histogram] ERROR");
        $finish;
    end

endmodule
